// ===== rtl/core/sfa_pkg.sv =====
// Package for the segment fit allocator: shared types and constants.
// Used by segment_fit_allocator and its testbench.
`default_nettype none
package sfa_pkg;
  localparam logic [1:0] KIND_FREE   = 2'd3;
  localparam logic [1:0] TYPE_CREW   = 2'd2;
  localparam logic [31:0] OWNER_NONE = 32'hFFFF_FFFF;
  localparam logic       OP_ALLOC    = 1'b0;
  localparam logic       OP_RELEASE  = 1'b1;
  localparam logic       REG_FIT     = 1'b0;
  localparam logic       REG_MSIZE   = 1'b1;
  localparam logic [15:0] MSIZE_RESET = 16'd4096;
endpackage
`default_nettype wire

// ===== rtl/core/sfa_cell.sv =====
// One table cell of the segment fit allocator: holds a segment entry and
// rotates it to its neighbor when the ring shifts. Stands on its own.
`default_nettype none
module sfa_cell #(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          shift,
  input  wire logic          load,
  input  wire logic [AW-1:0] in_start,
  input  wire logic [AW-1:0] in_length,
  input  wire logic [1:0]    in_kind,
  input  wire logic [31:0]   in_owner,
  output logic      [AW-1:0] start,
  output logic      [AW-1:0] length,
  output logic      [1:0]    kind,
  output logic      [31:0]   owner
);
  // Hold unless the ring advances or the head cell is rewritten.
  always_ff @(posedge clk) begin
    if (shift || load) begin
      start  <= in_start;
      length <= in_length;
      kind   <= in_kind;
      owner  <= in_owner;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/segment_fit_allocator.sv =====
// Top level of the segment fit allocator: a ring of table cells with a
// sequencer at the head. Depends on sfa_pkg and sfa_cell.
//
// Use: items enter on s_axis (tdata = kind, req_size, seg_type, owner_id,
// release_addr from bit 0 up, padded to 72 bits); one result leaves on
// m_axis per item (tdata = start_addr, ok, padded to 24 bits).
// Configuration writes go through cfg_valid/cfg_ready/cfg_index/cfg_data;
// index 0 sets fit_mode, index 1 sets memory_size and clears the table.
// The table is a ring of MAX_SEGMENTS cells. Each item rotates the ring
// once fully to scan and once more to apply the update at the chosen
// entry, and the result becomes valid when the second rotation is done.
// One item is in work at a time. The result sits in an output register;
// when the receiver stalls, the block holds it and accepts no new item
// until it is taken. Reset restores fit_mode 0, memory_size 4096 and one
// free segment covering the memory; the reinit is one full rotation of
// the ring, during which no item is accepted. A memory_size write starts
// the same reinit once the block is idle and no further write is being
// accepted; input holds off while a configuration write is pending.
`default_nettype none
module segment_fit_allocator #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_WIDTH   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // kind, req_size, seg_type, owner_id, release_addr
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // start_addr, ok
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int N  = MAX_SEGMENTS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int AW = ADDR_WIDTH;

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_SCAN, S_APPLY, S_OUT} state_t;
  state_t state;

  logic [AW-1:0] c_start [N];
  logic [AW-1:0] c_len   [N];
  logic [1:0]    c_kind  [N];
  logic [31:0]   c_owner [N];
  logic [AW-1:0] h_start, h_len;
  logic [1:0]    h_kind;
  logic [31:0]   h_owner;
  logic          shift, load;

  // Ring: cell i takes from cell i+1; the last cell takes the head value.
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_last
      sfa_cell #(.AW(AW)) u_cell (
        .clk, .shift, .load(load),
        .in_start(h_start), .in_length(h_len), .in_kind(h_kind), .in_owner(h_owner),
        .start(c_start[i]), .length(c_len[i]), .kind(c_kind[i]), .owner(c_owner[i]));
    end else begin : g_mid
      sfa_cell #(.AW(AW)) u_cell (
        .clk, .shift, .load(load),
        .in_start(c_start[i+1]), .in_length(c_len[i+1]), .in_kind(c_kind[i+1]),
        .in_owner(c_owner[i+1]),
        .start(c_start[i]), .length(c_len[i]), .kind(c_kind[i]), .owner(c_owner[i]));
    end
  end

  logic          fit_mode;
  logic [15:0]   memory_size;
  logic [CW-1:0] count;
  logic [IW-1:0] pos;
  logic          op;
  logic [AW-1:0] rsize, raddr;
  logic [1:0]    rtype;
  logic [31:0]   rowner;
  logic          found;
  logic [IW-1:0] pick;
  logic [AW-1:0] pick_start, pick_len;
  logic          res_ok, do_split;
  logic [15:0]   res_addr;
  logic          init_req;

  logic          live, fits, better, match;
  logic [CW-1:0] pos_ext;
  assign pos_ext = CW'(pos);
  assign live   = pos_ext < count;
  assign fits   = live && (c_kind[0] == sfa_pkg::KIND_FREE) && (c_len[0] >= rsize);
  assign better = fit_mode ? (c_len[0] < pick_len) : (c_start[0] < pick_start);
  assign match  = live && (c_start[0] == raddr);

  // Hold input off while a reinit is pending or a write is offered.
  assign s_axis_tready = (state == S_IDLE) && !init_req && !cfg_valid;
  assign cfg_ready     = (state == S_IDLE) || (state == S_INIT);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {7'd0, res_ok, res_addr};
  assign shift = (state == S_INIT) || (state == S_SCAN) || (state == S_APPLY);
  assign load  = 1'b0;

  // Head value fed into the tail of the ring.
  always_comb begin
    h_start = c_start[0];
    h_len   = c_len[0];
    h_kind  = c_kind[0];
    h_owner = c_owner[0];
    if (state == S_INIT) begin
      h_start = '0;
      h_len   = (pos == '0) ? AW'(memory_size) : '0;
      h_kind  = sfa_pkg::KIND_FREE;
      h_owner = sfa_pkg::OWNER_NONE;
    end else if (state == S_APPLY) begin
      if (res_ok && pos == pick) begin
        if (op == sfa_pkg::OP_RELEASE) begin
          h_kind  = sfa_pkg::KIND_FREE;
          h_owner = sfa_pkg::OWNER_NONE;
        end else begin
          h_kind = rtype;
          h_len  = rsize;
          if (rtype != sfa_pkg::TYPE_CREW) h_owner = rowner;
        end
      end else if (res_ok && do_split && pos_ext == count) begin
        h_start = pick_start + rsize;
        h_len   = pick_len - rsize;
        h_kind  = sfa_pkg::KIND_FREE;
        h_owner = sfa_pkg::OWNER_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      fit_mode    <= 1'b0;
      memory_size <= sfa_pkg::MSIZE_RESET;
      pos         <= '0;
      count       <= CW'(1);
      init_req    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sfa_pkg::REG_FIT) fit_mode <= cfg_data[0];
        else begin
          memory_size <= cfg_data;
          init_req    <= 1'b1;
        end
      end
      unique case (state)
        S_INIT: begin
          // Sweep the ring once writing entry 0 and clearing the rest.
          pos   <= pos + 1'b1;
          count <= CW'(1);
          if (pos == IW'(N - 1)) begin
            pos   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (init_req && !(cfg_valid && cfg_ready)) begin
            init_req <= 1'b0;
            pos      <= '0;
            state    <= S_INIT;
          end else if (s_axis_tvalid && s_axis_tready) begin
            op     <= s_axis_tdata[0];
            rsize  <= AW'(s_axis_tdata[16:1]);
            rtype  <= s_axis_tdata[18:17];
            rowner <= s_axis_tdata[50:19];
            raddr  <= AW'(s_axis_tdata[66:51]);
            found  <= 1'b0;
            pos    <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          pos <= pos + 1'b1;
          if (op == sfa_pkg::OP_ALLOC) begin
            if (fits && (!found || better)) begin
              found <= 1'b1; pick <= pos;
              pick_start <= c_start[0]; pick_len <= c_len[0];
            end
          end else if (match) begin
            found <= 1'b1; pick <= pos;
          end
          if (pos == IW'(N - 1)) begin
            pos <= '0;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          pos <= pos + 1'b1;
          if (pos == IW'(N - 1)) begin
            pos <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // Grow the table only once the result has left, so it stays stable.
          if (m_axis_tready) begin
            if (res_ok && do_split) count <= count + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  // Result decided from scan outcome; valid during APPLY and OUT.
  always_comb begin
    do_split = (op == sfa_pkg::OP_ALLOC) && (pick_len != rsize);
    if (op == sfa_pkg::OP_RELEASE) begin
      res_ok   = found;
      res_addr = 16'(raddr);
    end else begin
      res_ok = found && (rsize != '0) && (rtype != sfa_pkg::KIND_FREE)
               && !(do_split && count >= CW'(N));
      res_addr = res_ok ? 16'(pick_start) : 16'd0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sfa_checker.sv =====
// Port-level checker for the segment fit allocator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module sfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result without processing time");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
    else $error("padding bits set");
endmodule
bind segment_fit_allocator sfa_checker u_sfa_checker (.*);
`default_nettype wire

// ===== tb/segment_fit_allocator_test.sv =====
// Testbench for segment_fit_allocator: drives allocate and release items,
// predicts each result from its own copy of the segment table and checks it.
// Depends on sfa_pkg and the segment_fit_allocator RTL.
`default_nettype none

class seg_table_scoreboard;
  localparam int NSEG = 64;
  bit         fit_mode;
  bit [15:0]  mem_size;
  bit [15:0]  t_start [NSEG];
  bit [15:0]  t_len [NSEG];
  bit [1:0]   t_kind [NSEG];
  bit [31:0]  t_owner [NSEG];
  int         t_count;
  bit [16:0]  pending_results [$];
  int         errors;
  int         checked;
  int         ok_allocs;
  int         ok_releases;

  function void clear_table();
    for (int i = 0; i < NSEG; i++) begin
      t_start[i] = '0;
      t_len[i] = '0;
      t_kind[i] = sfa_pkg::KIND_FREE;
      t_owner[i] = sfa_pkg::OWNER_NONE;
    end
    t_len[0] = mem_size;
    t_count = 1;
  endfunction

  function void reset_state();
    fit_mode = 1'b0;
    mem_size = sfa_pkg::MSIZE_RESET;
    errors = 0;
    checked = 0;
    ok_allocs = 0;
    ok_releases = 0;
    clear_table();
  endfunction

  function void write_reg(bit idx, bit [15:0] val);
    if (idx == sfa_pkg::REG_FIT) begin
      fit_mode = val[0];
    end else begin
      mem_size = val;
      clear_table();
    end
  endfunction

  // Note an accepted item: update the table and queue the expected result.
  function void note_item(bit op, bit [15:0] size, bit [1:0] typ, bit [31:0] owner,
                          bit [15:0] raddr);
    bit [15:0] addr;
    bit        ok;
    int        pick;
    addr = '0;
    ok = 1'b0;
    pick = -1;
    if (op == sfa_pkg::OP_ALLOC) begin
      if (size != 0 && typ != sfa_pkg::KIND_FREE) begin
        for (int i = 0; i < t_count; i++) begin
          if (t_kind[i] == sfa_pkg::KIND_FREE && t_len[i] >= size) begin
            if (pick < 0) pick = i;
            else if (!fit_mode && t_start[i] < t_start[pick]) pick = i;
            else if (fit_mode && t_len[i] < t_len[pick]) pick = i;
          end
        end
        if (pick >= 0 && (t_len[pick] == size || t_count < NSEG)) begin
          if (t_len[pick] != size) begin
            t_start[t_count] = t_start[pick] + size;
            t_len[t_count] = t_len[pick] - size;
            t_kind[t_count] = sfa_pkg::KIND_FREE;
            t_owner[t_count] = sfa_pkg::OWNER_NONE;
            t_count++;
          end
          t_kind[pick] = typ;
          if (typ != sfa_pkg::TYPE_CREW) t_owner[pick] = owner;
          t_len[pick] = size;
          addr = t_start[pick];
          ok = 1'b1;
          ok_allocs++;
        end
      end
    end else begin
      addr = raddr;
      for (int i = 0; i < t_count; i++)
        if (t_start[i] == raddr) pick = i;
      if (pick >= 0) begin
        t_kind[pick] = sfa_pkg::KIND_FREE;
        t_owner[pick] = sfa_pkg::OWNER_NONE;
        ok = 1'b1;
        ok_releases++;
      end
    end
    pending_results.push_back({ok, addr});
  endfunction

  function void check_result(bit [23:0] data);
    bit [16:0] exp_res;
    checked++;
    if (pending_results.size() == 0) begin
      $error("result with nothing expected: start_addr %0d ok %0d", data[15:0], data[16]);
      errors++;
      return;
    end
    exp_res = pending_results.pop_front();
    if (data[15:0] != exp_res[15:0]) begin
      $error("start_addr expected %0d actual %0d", exp_res[15:0], data[15:0]);
      errors++;
    end
    if (data[16] != exp_res[16]) begin
      $error("ok expected %0d actual %0d", exp_res[16], data[16]);
      errors++;
    end
  endfunction

  // Pick a start address that is known, mostly a used one, for release items.
  function bit [15:0] known_addr();
    int used [$];
    for (int i = 0; i < t_count; i++)
      if (t_kind[i] != sfa_pkg::KIND_FREE) used.push_back(i);
    if (used.size() > 0 && $urandom_range(0, 4) != 0)
      return t_start[used[$urandom_range(0, used.size() - 1)]];
    return t_start[$urandom_range(0, t_count - 1)];
  endfunction
endclass

module segment_fit_allocator_test;

  // Each item rotates the ring twice; ITEM_LATENCY is chosen to exceed that.
  localparam int ITEM_LATENCY = 200;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;  // kind, req_size, seg_type, owner_id, release_addr
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;  // start_addr, ok
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  seg_table_scoreboard seg_model;
  int  cycle_count;
  bit  sink_enable;
  int  items_sent;

  segment_fit_allocator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stop a hung run: print the fail line and end.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: check every taken item, stall a random number of cycles
  // between items, with stretches of no stall at all.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (sink_enable);
    forever begin
      if ($urandom_range(0, 3) == 0) stall = 0;
      else stall = $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      seg_model.check_result(m_axis_tdata);
    end
  end

  function automatic bit [71:0] owner_low_pad(bit [15:0] raddr, bit [31:0] owner,
                                              bit [1:0] typ, bit [15:0] size, bit op);
    return {5'd0, raddr, owner, typ, size, op};
  endfunction

  // Send one item: hold tvalid until the block takes it, then drop it.
  task automatic send_item(bit op, bit [15:0] size, bit [1:0] typ, bit [31:0] owner,
                           bit [15:0] raddr, bit gap);
    if (gap) repeat ($urandom_range(0, 12)) @(posedge clk);
    s_axis_tdata <= {owner_low_pad(raddr, owner, typ, size, op)};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    seg_model.note_item(op, size, typ, owner, raddr);
    items_sent++;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected result has arrived, then let the block settle.
  task automatic drain();
    while (seg_model.pending_results.size() != 0) @(posedge clk);
    repeat (ITEM_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, bit [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    seg_model.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random phase: mostly allocations of sizes that fit, releases of known
  // addresses, a few odd items (zero size, free type, unknown addresses).
  task automatic random_phase(int count);
    bit [15:0] size;
    bit [15:0] raddr;
    bit [1:0]  typ;
    int        pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      typ = 2'($urandom_range(0, 2));
      if (pick < 3) typ = sfa_pkg::KIND_FREE;
      if (pick < 55) begin
        case ($urandom_range(0, 5))
          0: size = 16'($urandom);
          1: size = 16'd1;
          2: size = 16'(1 << $urandom_range(0, 15));
          default: size = 16'($urandom_range(1, seg_model.mem_size / 8 + 1));
        endcase
        if (pick == 10) size = '0;
        send_item(sfa_pkg::OP_ALLOC, size, typ, $urandom, 16'($urandom), 1'b1);
      end else begin
        if (pick < 92) raddr = seg_model.known_addr();
        else raddr = 16'($urandom);
        send_item(sfa_pkg::OP_RELEASE, 16'($urandom), 2'($urandom), $urandom, raddr,
                  1'b1);
      end
    end
  endtask

  initial begin
    seg_model = new();
    seg_model.reset_state();
    items_sent = 0;
    sink_enable = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    sink_enable = 1'b1;

    // Directed: default table, first fit.
    send_item(sfa_pkg::OP_ALLOC, 16'd0, 2'd0, 32'h1, 16'd0, 1'b0);           // zero request
    send_item(sfa_pkg::OP_ALLOC, 16'd16, sfa_pkg::KIND_FREE, 32'h2, 16'd0, 1'b0); // free type
    send_item(sfa_pkg::OP_ALLOC, 16'hFFFF, 2'd0, 32'h3, 16'd0, 1'b0);        // nothing fits
    send_item(sfa_pkg::OP_ALLOC, 16'd100, 2'd0, 32'hFFFF_FFFF, 16'd0, 1'b0);
    send_item(sfa_pkg::OP_ALLOC, 16'd50, 2'd1, 32'h0, 16'd0, 1'b0);
    send_item(sfa_pkg::OP_ALLOC, 16'd30, sfa_pkg::TYPE_CREW, 32'hA5A5_5A5A, 16'd0,
              1'b0);                                                         // crew owner
    send_item(sfa_pkg::OP_RELEASE, 16'hFFFF, 2'd3, 32'hFFFF_FFFF, 16'd100, 1'b0);
    send_item(sfa_pkg::OP_RELEASE, 16'd0, 2'd0, 32'd0, 16'd100, 1'b0);       // free one
    send_item(sfa_pkg::OP_RELEASE, 16'd0, 2'd0, 32'd0, 16'hFFFF, 1'b0);      // unknown
    send_item(sfa_pkg::OP_ALLOC, 16'd40, 2'd0, 32'h5, 16'd0, 1'b0);          // lowest start
    send_item(sfa_pkg::OP_RELEASE, 16'd0, 2'd0, 32'd0, 16'd0, 1'b0);
    drain();

    // Best fit, then fit mode write leaves the table alone.
    write_reg(sfa_pkg::REG_FIT, 16'd1);
    send_item(sfa_pkg::OP_ALLOC, 16'd5, 2'd1, 32'h6, 16'd0, 1'b0);           // smallest free
    send_item(sfa_pkg::OP_ALLOC, 16'd5, 2'd1, 32'h7, 16'd0, 1'b0);
    drain();

    // Largest memory; exact fit of everything.
    write_reg(sfa_pkg::REG_MSIZE, 16'hFFFF);
    send_item(sfa_pkg::OP_ALLOC, 16'hFFFF, 2'd0, 32'h8, 16'd0, 1'b0);
    send_item(sfa_pkg::OP_ALLOC, 16'd1, 2'd0, 32'h9, 16'd0, 1'b0);
    send_item(sfa_pkg::OP_RELEASE, 16'd0, 2'd0, 32'd0, 16'd0, 1'b0);
    drain();

    // Smallest memory, then fill the table to test the table-full case.
    write_reg(sfa_pkg::REG_MSIZE, 16'd1);
    send_item(sfa_pkg::OP_ALLOC, 16'd1, sfa_pkg::TYPE_CREW, 32'hA, 16'd0, 1'b0);
    send_item(sfa_pkg::OP_ALLOC, 16'd1, sfa_pkg::TYPE_CREW, 32'hB, 16'd0, 1'b0);
    drain();
    write_reg(sfa_pkg::REG_FIT, 16'd0);
    write_reg(sfa_pkg::REG_MSIZE, 16'd200);
    for (int i = 0; i < 66; i++)
      send_item(sfa_pkg::OP_ALLOC, 16'd1, 2'($urandom_range(0, 2)), $urandom, 16'd0, 1'b1);
    send_item(sfa_pkg::OP_RELEASE, 16'd0, 2'd0, 32'd0, 16'd3, 1'b0);
    send_item(sfa_pkg::OP_ALLOC, 16'd1, 2'd0, 32'hC, 16'd0, 1'b0);           // exact fit
    send_item(sfa_pkg::OP_ALLOC, 16'd2, 2'd0, 32'hD, 16'd0, 1'b0);
    // Hold off until every result is back.
    drain();

    // Random phases across settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(sfa_pkg::REG_FIT, 16'($urandom_range(0, 1)));
      case (ph % 3)
        0: write_reg(sfa_pkg::REG_MSIZE, 16'($urandom_range(1, 65535)));
        1: write_reg(sfa_pkg::REG_MSIZE, 16'($urandom_range(64, 4096)));
        default: write_reg(sfa_pkg::REG_MSIZE, 16'hFFFF);
      endcase
      random_phase(90);
      drain();
    end

    $display("sent %0d items, checked %0d results: %0d allocations and %0d releases succeeded",
             items_sent, seg_model.checked, seg_model.ok_allocs, seg_model.ok_releases);
    $display("covered both fit modes, memory sizes 1 to 65535 and a full table");
    if (seg_model.errors == 0 && seg_model.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

`default_nettype wire
